### design/dmxg_pkg.sv
// Shared types, constants and arithmetic helpers for the group write sender.
`default_nettype none
package dmxg_pkg;

	localparam int NUM_CHANNELS_DEF = 512;
	localparam int ROW_BITS         = 32;

	localparam logic [1:0] KIND_MAP   = 2'd0;
	localparam logic [1:0] KIND_LEVEL = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [7:0] SWITCH_THRESHOLD = 8'd127;

	typedef struct packed {
		logic        mapped;
		logic        is_switch;
		logic [15:0] address;
		logic        primed;
		logic [7:0]  last_level;
	} chan_entry_t;

	// max(0, floor(level * 100 / 255) - 1); the division by 255 uses the
	// (x + 1 + (x >> 8)) >> 8 identity, which is exact for the 15-bit x used here.
	function automatic logic [6:0] percent_of(input logic [7:0] level);
		logic [14:0] x;
		logic [15:0] t;
		logic [7:0]  q;
		x = 15'(level) * 15'd100;
		t = 16'(x) + 16'd1 + 16'(x >> 8);
		q = t[15:8];
		return (q == 8'd0) ? 7'd0 : 7'(q - 8'd1);
	endfunction

	// Index of the lowest set bit of a pending row.
	function automatic logic [4:0] first_set(input logic [ROW_BITS-1:0] row);
		logic [4:0] idx;
		idx = 5'd0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (row[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### design/dmx_change_to_group_write_sender.sv
// Top level of the lighting channel to group write sender.
// The block holds a mapping table of NUM_CHANNELS lighting channels in a RAM and a
// pending bitmap in a second RAM of 32-bit rows. Every request on the slave side
// carries a kind in s_tuser: a map request binds a channel to a group address and a
// switch or value type, a level request records a channel level and may mark it as
// pending, and a tick request sends the lowest-numbered pending channel on the master
// side. After reset the block sweeps both RAMs and accepts no request during that
// pass. A map or level request then passes through accept, RAM read and
// read-modify-write steps; a request of the reserved kind, or for a channel beyond
// the table, is dropped in its accept cycle. A tick reads the pending rows one by
// one, at most ceil(NUM_CHANNELS/32), each with a scan and a check step through the
// single pending RAM port, and when a channel is found it fetches the entry, scales
// the level and loads the output register. Loading the output register waits for
// as long as an earlier result is still stalled there. Once loaded, the
// result waits in the output register, so further map and level requests are taken
// while it is stalled.
`default_nettype none
module dmx_change_to_group_write_sender #(
	parameter int NUM_CHANNELS = dmxg_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: ignore_first.
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	// Request stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [8:0] channel, [16:9] level, [32:17] group_address, [33] is_switch, rest zero.
	input  wire logic [39:0] s_tdata,
	// [1:0] kind.
	input  wire logic [1:0]  s_tuser,
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] dest_address, [22:16] payload, [23] zero.
	output logic      [23:0] m_tdata,
	// [0] dest_is_switch.
	output logic             m_tuser
);

	localparam int CW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RB      = dmxg_pkg::ROW_BITS;
	localparam int ROWS    = (NUM_CHANNELS + RB - 1) / RB;
	localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int XW      = CW + 5;
	localparam int EW      = $bits(dmxg_pkg::chan_entry_t);
	localparam logic [CW:0] ROWS_C  = (CW + 1)'(ROWS);
	localparam logic [RW:0] ROWS_R  = (RW + 1)'(ROWS);
	localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

	// One-hot sequencer states.
	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_RD    = 8'b0000_0100,
		ST_UPD   = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_CHK   = 8'b0010_0000,
		ST_FETCH = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic          ign_q;
	logic [CW-1:0] clr_q;
	logic [1:0]    kind_q;
	logic [CW-1:0] ch_q;
	logic [7:0]    lvl_q;
	logic [15:0]   addr_q;
	logic          sw_q;
	logic [RW:0]   row_q;

	logic [15:0]   res_addr_q;
	logic          res_sw_q;
	logic [6:0]    res_pay_q;

	logic          m_tvalid_q;
	logic [15:0]   m_addr_q;
	logic [6:0]    m_pay_q;
	logic          m_sw_q;

	// Request fields.
	logic [8:0]  s_channel;
	logic [7:0]  s_level;
	logic [15:0] s_group_address;
	logic        s_is_switch;

	assign s_channel       = s_tdata[8:0];
	assign s_level         = s_tdata[16:9];
	assign s_group_address = s_tdata[32:17];
	assign s_is_switch     = s_tdata[33];

	// RAM ports.
	logic                  ent_we;
	logic [CW-1:0]         ent_waddr;
	dmxg_pkg::chan_entry_t ent_wdata;
	logic [CW-1:0]         ent_raddr;
	dmxg_pkg::chan_entry_t ent_rd;
	logic [EW-1:0]         ent_rd_raw;

	logic                  pnd_we;
	logic [RW-1:0]         pnd_waddr;
	logic [RB-1:0]         pnd_wdata;
	logic [RW-1:0]         pnd_raddr;
	logic [RB-1:0]         pnd_rd;

	assign ent_rd = dmxg_pkg::chan_entry_t'(ent_rd_raw);

	// Position of the latched channel in the pending bitmap.
	logic [XW-1:0] ch_x;
	logic [RW-1:0] ch_row;
	logic [RB-1:0] ch_mask;

	assign ch_x    = XW'(ch_q);
	assign ch_row  = ch_x[RW+4:5];
	assign ch_mask = RB'(1) << ch_x[4:0];

	// Lowest pending channel in the row that the scan has just read.
	logic [4:0]    hit_bit;
	logic [CW-1:0] hit_ch;
	logic          row_busy;

	assign hit_bit  = dmxg_pkg::first_set(pnd_rd);
	assign hit_ch   = CW'({row_q[RW-1:0], hit_bit});
	assign row_busy = (pnd_rd != '0);

	logic in_range;
	assign in_range = 32'(s_channel) < 32'(NUM_CHANNELS);

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_pay_q, m_addr_q};
	assign m_tuser  = m_sw_q;

	// RAM control for every sequencer step.
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = ch_q;
		ent_wdata = ent_rd;
		ent_raddr = ch_q;
		pnd_we    = 1'b0;
		pnd_waddr = ch_row;
		pnd_wdata = pnd_rd;
		pnd_raddr = ch_row;
		case (state_q)
			ST_CLR: begin
				// Reset pass: unmap every channel and empty every pending row.
				ent_we    = 1'b1;
				ent_waddr = clr_q;
				ent_wdata = '0;
				pnd_we    = ({1'b0, clr_q} < ROWS_C);
				pnd_waddr = RW'(clr_q);
				pnd_wdata = '0;
			end
			ST_UPD: begin
				if (kind_q == dmxg_pkg::KIND_MAP) begin
					ent_we               = 1'b1;
					ent_wdata.mapped     = 1'b1;
					ent_wdata.is_switch  = sw_q;
					ent_wdata.address    = addr_q;
					ent_wdata.primed     = !ign_q;
					ent_wdata.last_level = 8'd0;
					pnd_we               = 1'b1;
					pnd_wdata            = pnd_rd & ~ch_mask;
				end else if (ent_rd.mapped) begin
					if (!ent_rd.primed) begin
						// With ignore_first set, the first level after mapping only primes the entry.
						ent_we               = 1'b1;
						ent_wdata.primed     = 1'b1;
						ent_wdata.last_level = lvl_q;
					end else if (lvl_q != ent_rd.last_level) begin
						ent_we               = 1'b1;
						ent_wdata.last_level = lvl_q;
						pnd_we               = 1'b1;
						pnd_wdata            = pnd_rd | ch_mask;
					end
				end
			end
			ST_SCAN: begin
				pnd_raddr = row_q[RW-1:0];
			end
			ST_CHK: begin
				if (row_busy) begin
					pnd_we    = 1'b1;
					pnd_waddr = row_q[RW-1:0];
					pnd_wdata = pnd_rd & ~(RB'(1) << hit_bit);
					ent_raddr = hit_ch;
				end
			end
			default: begin
			end
		endcase
	end

	dmxg_ram #(
		.DEPTH (NUM_CHANNELS),
		.WIDTH (EW),
		.AW    (CW)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rd_raw)
	);

	dmxg_ram #(
		.DEPTH (ROWS),
		.WIDTH (RB),
		.AW    (RW)
	) u_pending_ram (
		.clk   (clk),
		.we    (pnd_we),
		.waddr (pnd_waddr),
		.wdata (pnd_wdata),
		.raddr (pnd_raddr),
		.rdata (pnd_rd)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ign_q <= cfg_wr_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == LAST_CH) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == dmxg_pkg::KIND_TICK) begin
							row_q   <= '0;
							state_q <= ST_SCAN;
						end else if ((s_tuser == dmxg_pkg::KIND_MAP ||
						              s_tuser == dmxg_pkg::KIND_LEVEL) && in_range) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (row_busy) begin
						state_q <= ST_FETCH;
					end else if (row_q + (RW + 1)'(1) == ROWS_R) begin
						state_q <= ST_IDLE;
					end else begin
						row_q   <= row_q + (RW + 1)'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latched request fields; no reset needed.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			ch_q   <= CW'(s_channel);
			lvl_q  <= s_level;
			addr_q <= s_group_address;
			sw_q   <= s_is_switch;
		end
	end

	// Result of the found channel, scaled and held here while it waits for the output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			res_addr_q <= ent_rd.address;
			res_sw_q   <= ent_rd.is_switch;
			if (ent_rd.is_switch) begin
				res_pay_q <= {6'd0, ent_rd.last_level > dmxg_pkg::SWITCH_THRESHOLD};
			end else begin
				res_pay_q <= dmxg_pkg::percent_of(ent_rd.last_level);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_addr_q <= res_addr_q;
			m_sw_q   <= res_sw_q;
			m_pay_q  <= res_pay_q;
		end
	end

`ifndef SYNTHESIS
	// A value payload stays within 0..99 and a switch payload is a single bit.
	a_payload_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_sw_q ? (m_pay_q <= 7'd1) : (m_pay_q <= 7'd99)))
		else $error("payload out of range");

	// The scan only finds pending channels inside the table.
	a_hit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && row_busy) |-> (32'(hit_ch) < 32'(NUM_CHANNELS)))
		else $error("pending bit beyond the channel table");

	// Sending a channel clears exactly one pending bit of its row.
	a_one_bit_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && row_busy) |->
			($countones(pnd_wdata) + 1 == $countones(pnd_rd)))
		else $error("pending row update cleared the wrong bits");

	// A pending channel is always a mapped one.
	a_sent_is_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> ent_rd.mapped)
		else $error("pending channel without a mapping");
`endif

endmodule
`default_nettype wire

### design/dmxg_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module dmxg_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 27,
	parameter int AW    = 9
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
